>>> sv/bgtf_pkg.sv
// ----------------------------------------------------------------------------
// bgtf_pkg: shared types and constants of the background tile fetcher
// Widths, dot schedule points, fetch kinds, register indexes and item structs.
// ----------------------------------------------------------------------------
package bgtf_pkg;

  // Default screen size in pixels.
  localparam int unsigned SCREEN_WIDTH_DEF  = 256;
  localparam int unsigned SCREEN_HEIGHT_DEF = 240;

  // Field widths.
  localparam int unsigned DOT_W      = 9;
  localparam int unsigned VADDR_W    = 15;
  localparam int unsigned FADDR_W    = 14;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SHIFT_W    = 16;
  localparam int unsigned FINE_X_W   = 3;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned PIX_W      = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned STEP_W     = 4;

  // Fetch sequencer step count; the step register sits here when idle.
  localparam logic [STEP_W-1:0] STEP_IDLE = 4'd8;

  // Points of the dot schedule.
  localparam logic [DOT_W-1:0] DOT_PIX_FIRST   = 9'd2;
  localparam logic [DOT_W-1:0] DOT_PIX_LAST    = 9'd257;
  localparam logic [DOT_W-1:0] DOT_HCOPY       = 9'd257;
  localparam logic [DOT_W-1:0] DOT_INC_Y       = 9'd256;
  localparam logic [DOT_W-1:0] DOT_INC_X_FIRST = 9'd8;
  localparam logic [DOT_W-1:0] DOT_INC_X_LAST  = 9'd256;
  localparam logic [DOT_W-1:0] DOT_PRE_INC_A   = 9'd328;
  localparam logic [DOT_W-1:0] DOT_PRE_INC_B   = 9'd336;
  localparam logic [DOT_W-1:0] DOT_TILE_FIRST  = 9'd1;
  localparam logic [DOT_W-1:0] DOT_RELOAD_FIRST = 9'd9;
  localparam logic [DOT_W-1:0] DOT_TILE_LAST   = 9'd249;
  localparam logic [DOT_W-1:0] DOT_PRE_TILE_A  = 9'd321;
  localparam logic [DOT_W-1:0] DOT_PRE_TILE_B  = 9'd329;
  localparam logic [DOT_W-1:0] DOT_PRE_RELOAD_B = 9'd337;
  localparam logic [DOT_W-1:0] DOT_PRE_SHIFT_FIRST = 9'd322;
  localparam logic [DOT_W-1:0] DOT_PRE_SHIFT_LAST  = 9'd337;
  localparam logic [DOT_W-1:0] DOT_DUMMY_NT_A  = 9'd338;
  localparam logic [DOT_W-1:0] DOT_DUMMY_NT_B  = 9'd340;

  // Low three bits of a dot at the tile boundaries.
  localparam logic [2:0] TILE_PHASE_INC    = 3'd0;
  localparam logic [2:0] TILE_PHASE_START  = 3'd1;

  // Sequencer steps that issue a fetch.
  localparam logic [STEP_W-1:0] STEP_NT  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_AT  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_PLO = 4'd4;
  localparam logic [STEP_W-1:0] STEP_PHI = 4'd6;

  // Scroll address fields.
  localparam logic [4:0] COARSE_LAST     = 5'd31;
  localparam logic [4:0] COARSE_Y_WRAP   = 5'd29;
  localparam logic [2:0] FINE_Y_LAST     = 3'd7;

  // Kind of the fetch whose byte returns with the next request.
  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_NT   = 3'd1,
    KIND_AT   = 3'd2,
    KIND_PLO  = 3'd3,
    KIND_PHI  = 3'd4
  } fetch_kind_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_ADDRESS  = 2'd0,
    REG_FINE_SCROLL_X = 2'd1,
    REG_PATTERN_TABLE = 2'd2
  } cfg_reg_t;

  // One input request.
  typedef struct packed {
    logic [DOT_W-1:0]  dot;
    logic              visible_line;
    logic              first_line;
    logic              render_en;
    logic              bg_en;
    logic [BYTE_W-1:0] fetch_data;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic               fetch_valid;
    logic [FADDR_W-1:0] fetch_addr;
    logic               pixel_valid;
    logic [PIX_W-1:0]   pixel_value;
    logic [POS_W-1:0]   pix_row;
    logic [POS_W-1:0]   pix_col;
    logic               frame_done;
  } out_item_t;

endpackage

>>> sv/bgtf_channels.sv
// ----------------------------------------------------------------------------
// bgtf channels: valid/ready interfaces of the background tile fetcher
// Input dot channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------

// Input channel: one dot per request.
interface bgtf_in_if import bgtf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DOT_W-1:0]  dot;
  logic              visible_line;
  logic              first_line;
  logic              render_en;
  logic              bg_en;
  logic [BYTE_W-1:0] fetch_data;

  modport source (
    output valid, dot, visible_line, first_line, render_en, bg_en, fetch_data,
    input  ready
  );
  modport sink (
    input  valid, dot, visible_line, first_line, render_en, bg_en, fetch_data,
    output ready
  );
endinterface

// Result channel: fetch request and pixel of one dot.
interface bgtf_out_if import bgtf_pkg::*;;
  logic               valid;
  logic               ready;
  logic               fetch_valid;
  logic [FADDR_W-1:0] fetch_addr;
  logic               pixel_valid;
  logic [PIX_W-1:0]   pixel_value;
  logic [POS_W-1:0]   pix_row;
  logic [POS_W-1:0]   pix_col;
  logic               frame_done;

  modport source (
    output valid, fetch_valid, fetch_addr, pixel_valid, pixel_value, pix_row, pix_col,
           frame_done,
    input  ready
  );
  modport sink (
    input  valid, fetch_valid, fetch_addr, pixel_valid, pixel_value, pix_row, pix_col,
           frame_done,
    output ready
  );
endinterface

// Configuration write channel.
interface bgtf_cfg_if import bgtf_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/bg_tile_fetch_shift_render.sv
// ----------------------------------------------------------------------------
// bg_tile_fetch_shift_render: background tile fetch, shift and pixel output
// Runs the 8-dot fetch schedule, maintains the scroll address and shifters,
// and produces one result per dot, carrying any fetch request and background pixel.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake     | Payload
//  ---------+-----------+---------------+------------------------------------------
//  in_if    | sink      | valid / ready | dot, line flags, enables, fetch_data
//  out_if   | source    | valid / ready | fetch request, pixel, row, col, frame_done
//  cfg_if   | sink      | valid / ready | register index, write data
//
// One dot per clock is sustained while the result channel is not stalled; an
// accepted request goes through the input register, then one pass of dot logic
// into the result register. The dot logic updates the state in the same cycle as
// it writes the result register, so consecutive dots follow without a gap.
// Reset (rst_n low, synchronous) empties both registers and clears all state.
// A stalled result holds the result register; the input register still takes
// one further request, after which in_if.ready drops. cfg_if is always ready.
//
module bg_tile_fetch_shift_render import bgtf_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bgtf_in_if.sink   in_if,
  bgtf_out_if.source out_if,
  bgtf_cfg_if.sink  cfg_if
);

  localparam logic [POS_W:0] COL_WRAP = (POS_W+1)'(SCREEN_WIDTH);
  localparam logic [POS_W:0] ROW_WRAP = (POS_W+1)'(SCREEN_HEIGHT);

  // Pipeline registers.
  logic      s1_v_r;
  in_item_t  s1_r;
  logic      out_v_r;
  out_item_t out_r;
  out_item_t res;
  logic      out_free;
  logic      fire;

  // Configuration registers.
  logic [VADDR_W-1:0]  temp_addr_r;
  logic [FINE_X_W-1:0] fine_x_r;
  logic                pat_table_r;

  // Dot state.
  logic [VADDR_W-1:0] vaddr_r,   vaddr_nxt;
  logic [BYTE_W-1:0]  nt_r,      nt_nxt;
  logic [1:0]         att_r,     att_nxt;
  logic [1:0]         asel_r,    asel_nxt;
  logic [BYTE_W-1:0]  plo_r,     plo_nxt;
  logic [BYTE_W-1:0]  phi_r,     phi_nxt;
  logic [SHIFT_W-1:0] pat_lo_r,  pat_lo_nxt;
  logic [SHIFT_W-1:0] pat_hi_r,  pat_hi_nxt;
  logic [SHIFT_W-1:0] pal_lo_r,  pal_lo_nxt;
  logic [SHIFT_W-1:0] pal_hi_r,  pal_hi_nxt;
  logic [STEP_W-1:0]  step_r,    step_nxt;
  fetch_kind_t        pend_r,    pend_nxt;
  logic [POS_W-1:0]   row_r,     row_nxt;
  logic [POS_W-1:0]   col_r,     col_nxt;

  // Helpers of the dot logic.
  logic [DOT_W-1:0] dot;
  logic [3:0]       bit_sel;
  logic [4:0]       tile_row;
  logic             do_inc, do_reload, do_restart;

  // Handshake: the input register moves on whenever the result register can.
  assign out_free    = !out_v_r || out_if.ready;
  assign fire        = s1_v_r && out_free;
  assign in_if.ready = !s1_v_r || out_free;
  assign cfg_if.ready = 1'b1;

  // Result channel is driven straight from the result register.
  assign out_if.valid       = out_v_r;
  assign out_if.fetch_valid = out_r.fetch_valid;
  assign out_if.fetch_addr  = out_r.fetch_addr;
  assign out_if.pixel_valid = out_r.pixel_valid;
  assign out_if.pixel_value = out_r.pixel_value;
  assign out_if.pix_row     = out_r.pix_row;
  assign out_if.pix_col     = out_r.pix_col;
  assign out_if.frame_done  = out_r.frame_done;

  // Schedule decode of the registered dot.
  always_comb begin
    dot = s1_r.dot;
    do_inc = (dot >= DOT_INC_X_FIRST && dot <= DOT_INC_X_LAST && dot[2:0] == TILE_PHASE_INC)
             || dot == DOT_PRE_INC_A || dot == DOT_PRE_INC_B;
    do_reload = (dot >= DOT_RELOAD_FIRST && dot <= DOT_TILE_LAST
                 && dot[2:0] == TILE_PHASE_START)
                || dot == DOT_PRE_TILE_B || dot == DOT_PRE_RELOAD_B;
    do_restart = (dot >= DOT_TILE_FIRST && dot <= DOT_TILE_LAST
                  && dot[2:0] == TILE_PHASE_START)
                 || dot == DOT_PRE_TILE_A || dot == DOT_PRE_TILE_B;
  end

  // Dot logic: returned byte, pixel, shift, scroll update and reload, fetch.
  always_comb begin
    vaddr_nxt  = vaddr_r;
    nt_nxt     = nt_r;
    att_nxt    = att_r;
    asel_nxt   = asel_r;
    plo_nxt    = plo_r;
    phi_nxt    = phi_r;
    pat_lo_nxt = pat_lo_r;
    pat_hi_nxt = pat_hi_r;
    pal_lo_nxt = pal_lo_r;
    pal_hi_nxt = pal_hi_r;
    step_nxt   = step_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    res        = '0;
    bit_sel    = 4'd15 - {1'b0, fine_x_r};
    tile_row   = '0;

    // The byte of the previous request lands in its latch first.
    case (pend_r)
      KIND_NT:  nt_nxt = s1_r.fetch_data;
      KIND_AT: begin
        case (asel_r)
          2'd0:    att_nxt = s1_r.fetch_data[1:0];
          2'd1:    att_nxt = s1_r.fetch_data[3:2];
          2'd2:    att_nxt = s1_r.fetch_data[5:4];
          default: att_nxt = s1_r.fetch_data[7:6];
        endcase
      end
      KIND_PLO: plo_nxt = s1_r.fetch_data;
      KIND_PHI: phi_nxt = s1_r.fetch_data;
      default: ;
    endcase
    pend_nxt = KIND_NONE;

    // Pixel output and shifting.
    if (dot >= DOT_PIX_FIRST && dot <= DOT_PIX_LAST) begin
      if (s1_r.visible_line) begin
        if (dot == DOT_PIX_FIRST) begin
          if (s1_r.first_line) begin
            row_nxt = '0;
          end
          col_nxt = '0;
        end
        if (s1_r.bg_en) begin
          res.pixel_valid = 1'b1;
          res.pixel_value = {pal_hi_r[bit_sel], pal_lo_r[bit_sel],
                             pat_hi_r[bit_sel], pat_lo_r[bit_sel]};
          res.pix_row     = row_nxt;
          res.pix_col     = col_nxt;
        end
        res.frame_done = (dot == DOT_PIX_LAST);
        if ({1'b0, col_nxt} + 1'b1 >= COL_WRAP) begin
          col_nxt = '0;
          if ({1'b0, row_nxt} + 1'b1 >= ROW_WRAP) begin
            row_nxt = '0;
          end else begin
            row_nxt = row_nxt + 1'b1;
          end
        end else begin
          col_nxt = col_nxt + 1'b1;
        end
      end
      pat_lo_nxt = {pat_lo_r[SHIFT_W-2:0], 1'b0};
      pat_hi_nxt = {pat_hi_r[SHIFT_W-2:0], 1'b0};
      pal_lo_nxt = {pal_lo_r[SHIFT_W-2:0], 1'b0};
      pal_hi_nxt = {pal_hi_r[SHIFT_W-2:0], 1'b0};
    end else if (dot >= DOT_PRE_SHIFT_FIRST && dot <= DOT_PRE_SHIFT_LAST) begin
      pat_lo_nxt = {pat_lo_r[SHIFT_W-2:0], 1'b0};
      pat_hi_nxt = {pat_hi_r[SHIFT_W-2:0], 1'b0};
      pal_lo_nxt = {pal_lo_r[SHIFT_W-2:0], 1'b0};
      pal_hi_nxt = {pal_hi_r[SHIFT_W-2:0], 1'b0};
    end

    // Scroll address update and shifter reload.
    if (do_inc) begin
      if (s1_r.render_en) begin
        if (dot == DOT_INC_Y) begin
          if (vaddr_nxt[14:12] != FINE_Y_LAST) begin
            vaddr_nxt[14:12] = vaddr_nxt[14:12] + 1'b1;
          end else begin
            vaddr_nxt[14:12] = '0;
            tile_row = vaddr_nxt[9:5];
            if (tile_row == COARSE_Y_WRAP) begin
              tile_row = '0;
              vaddr_nxt[11] = ~vaddr_nxt[11];
            end else if (tile_row == COARSE_LAST) begin
              tile_row = '0;
            end else begin
              tile_row = tile_row + 1'b1;
            end
            vaddr_nxt[9:5] = tile_row;
          end
        end
        if (vaddr_nxt[4:0] == COARSE_LAST) begin
          vaddr_nxt[4:0] = '0;
          vaddr_nxt[10]  = ~vaddr_nxt[10];
        end else begin
          vaddr_nxt[4:0] = vaddr_nxt[4:0] + 1'b1;
        end
      end
    end else if (dot == DOT_HCOPY || do_reload) begin
      if (dot == DOT_HCOPY && s1_r.render_en) begin
        vaddr_nxt[10]  = temp_addr_r[10];
        vaddr_nxt[4:0] = temp_addr_r[4:0];
      end
      pat_lo_nxt[BYTE_W-1:0] = plo_nxt;
      pat_hi_nxt[BYTE_W-1:0] = phi_nxt;
      pal_lo_nxt[BYTE_W-1:0] = {BYTE_W{att_nxt[0]}};
      pal_hi_nxt[BYTE_W-1:0] = {BYTE_W{att_nxt[1]}};
    end

    // Fetch sequencer and read request.
    if (do_restart) begin
      step_nxt = '0;
    end
    if (dot == DOT_DUMMY_NT_A || dot == DOT_DUMMY_NT_B) begin
      res.fetch_valid = 1'b1;
      res.fetch_addr  = {2'b10, vaddr_nxt[11:0]};
      pend_nxt        = KIND_NT;
    end else if (step_nxt < STEP_IDLE) begin
      case (step_nxt)
        STEP_NT: begin
          res.fetch_valid = 1'b1;
          res.fetch_addr  = {2'b10, vaddr_nxt[11:0]};
          pend_nxt        = KIND_NT;
        end
        STEP_AT: begin
          res.fetch_valid = 1'b1;
          res.fetch_addr  = {2'b10, vaddr_nxt[11:10], 4'b1111, vaddr_nxt[9:7], vaddr_nxt[4:2]};
          asel_nxt        = {vaddr_nxt[6], vaddr_nxt[1]};
          pend_nxt        = KIND_AT;
        end
        STEP_PLO: begin
          res.fetch_valid = 1'b1;
          res.fetch_addr  = {1'b0, pat_table_r, nt_nxt, 1'b0, vaddr_nxt[14:12]};
          pend_nxt        = KIND_PLO;
        end
        STEP_PHI: begin
          res.fetch_valid = 1'b1;
          res.fetch_addr  = {1'b0, pat_table_r, nt_nxt, 1'b1, vaddr_nxt[14:12]};
          pend_nxt        = KIND_PHI;
        end
        default: ;
      endcase
    end
    if (step_nxt < STEP_IDLE) begin
      step_nxt = step_nxt + 1'b1;
    end
  end

  // Input and result registers, dot state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      temp_addr_r <= '0;
      fine_x_r    <= '0;
      pat_table_r <= 1'b0;
      vaddr_r     <= '0;
      nt_r        <= '0;
      att_r       <= '0;
      asel_r      <= '0;
      plo_r       <= '0;
      phi_r       <= '0;
      pat_lo_r    <= '0;
      pat_hi_r    <= '0;
      pal_lo_r    <= '0;
      pal_hi_r    <= '0;
      step_r      <= STEP_IDLE;
      pend_r      <= KIND_NONE;
      row_r       <= '0;
      col_r       <= '0;
    end else begin
      if (in_if.ready) begin
        s1_v_r <= in_if.valid;
      end
      if (out_free) begin
        out_v_r <= s1_v_r;
      end
      if (fire) begin
        vaddr_r  <= vaddr_nxt;
        nt_r     <= nt_nxt;
        att_r    <= att_nxt;
        asel_r   <= asel_nxt;
        plo_r    <= plo_nxt;
        phi_r    <= phi_nxt;
        pat_lo_r <= pat_lo_nxt;
        pat_hi_r <= pat_hi_nxt;
        pal_lo_r <= pal_lo_nxt;
        pal_hi_r <= pal_hi_nxt;
        step_r   <= step_nxt;
        pend_r   <= pend_nxt;
        row_r    <= row_nxt;
        col_r    <= col_nxt;
      end
      if (cfg_if.valid) begin
        case (cfg_reg_t'(cfg_if.index))
          REG_TEMP_ADDRESS:  temp_addr_r <= cfg_if.data[VADDR_W-1:0];
          REG_FINE_SCROLL_X: fine_x_r    <= cfg_if.data[FINE_X_W-1:0];
          REG_PATTERN_TABLE: pat_table_r <= cfg_if.data[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_r <= '{dot: in_if.dot, visible_line: in_if.visible_line,
                first_line: in_if.first_line, render_en: in_if.render_en,
                bg_en: in_if.bg_en, fetch_data: in_if.fetch_data};
    end
    if (fire) begin
      out_r <= res;
    end
  end

endmodule

>>> sv/bgtf_checker.sv
// ----------------------------------------------------------------------------
// bgtf_checker: port-level checks of the background tile fetcher
// Watches the channels of the top level and is attached to it by a bind.
// ----------------------------------------------------------------------------
module bgtf_checker import bgtf_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               fetch_valid,
  input logic [FADDR_W-1:0] fetch_addr,
  input logic               pixel_valid,
  input logic [PIX_W-1:0]   pixel_value,
  input logic [POS_W-1:0]   pix_row,
  input logic [POS_W-1:0]   pix_col,
  input logic               frame_done
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(fetch_valid) && $stable(fetch_addr)
      && $stable(pixel_valid) && $stable(pixel_value) && $stable(pix_row)
      && $stable(pix_col) && $stable(frame_done))
    else $error("result changed while stalled");

  // A request taken behind a stalled result fills the only free slot.
  a_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_valid && !out_ready |=> (out_ready || !in_ready))
    else $error("input accepted with both registers full");

  // No read address without a read request.
  a_fetch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !fetch_valid |-> fetch_addr == '0)
    else $error("fetch address set without a fetch");

  // Pixel fields are zero when no pixel is produced.
  a_pixel_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !pixel_valid |-> pixel_value == '0 && pix_row == '0 && pix_col == '0)
    else $error("pixel fields set without a pixel");

endmodule

bind bg_tile_fetch_shift_render bgtf_checker u_bgtf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .fetch_valid (out_if.fetch_valid),
  .fetch_addr  (out_if.fetch_addr),
  .pixel_valid (out_if.pixel_valid),
  .pixel_value (out_if.pixel_value),
  .pix_row     (out_if.pix_row),
  .pix_col     (out_if.pix_col),
  .frame_done  (out_if.frame_done)
);
